/* hdl/range_clipped_histogram_binner_core_assert.svh */
// Assertion macros for the histogram binner checker.
`ifndef RANGE_CLIPPED_HISTOGRAM_BINNER_CORE_ASSERT_SVH
`define RANGE_CLIPPED_HISTOGRAM_BINNER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RCHB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rchb check failed");
// Next-cycle implication.
`define RCHB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rchb check failed");
`endif

/* hdl/rchb_pkg.sv */
// ----------------------------------------------------------------------------
// rchb_pkg
// Shared types and codes of the range-clipped histogram binner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rchb_pkg;
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_RANGE_LOW  = 3'd0,
    REG_RANGE_HIGH = 3'd1,
    REG_BINS       = 3'd2,
    REG_SCALE      = 3'd3,
    REG_USE_EDGES  = 3'd4
  } reg_idx_t;

  // Token handed along the cell chain.
  typedef struct packed {
    logic        vld;
    logic        found;   // interval hit seen
    logic        top_eq;  // last cell in use: sample equals the top edge
    logic        top_gt;  // last cell in use: sample above the top edge
  } tok_t;
endpackage
`default_nettype wire

/* hdl/rchb_cell.sv */
// ----------------------------------------------------------------------------
// rchb_cell
// One edge cell: holds one edge, tests the sample token against its interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rchb_cell
  import rchb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load_en,
  input  wire logic signed [31:0] load_val,
  input  wire logic signed [31:0] next_edge,   // edge of the neighbour above
  input  wire logic               is_last,     // this cell is bin n-1
  input  wire logic               tok_in,      // token: sample under test
  input  wire logic signed [31:0] x,
  output logic signed [31:0]      edge_q,
  output tok_t                    res
);
  logic signed [31:0] edge_r;
  always_ff @(posedge clk) begin
    if (load_en) begin
      edge_r <= load_val;
    end
  end
  assign edge_q = edge_r;
  // Compare done in parallel; token selects whether it counts.
  // The last cell in use also checks the top edge held by its neighbour.
  always_comb begin
    res.vld    = tok_in;
    res.found  = (edge_r <= x) && (x < next_edge);
    res.top_eq = is_last && (x == next_edge);
    res.top_gt = is_last && (x > next_edge);
  end
  logic unused_rst;
  assign unused_rst = rst_n;
endmodule
`default_nettype wire

/* hdl/range_clipped_histogram_binner_core.sv */
// ----------------------------------------------------------------------------
// range_clipped_histogram_binner_core
// Histogram of Q16.16 samples with uniform or edge-table bins.
// ----------------------------------------------------------------------------
// Use: beats on in_* carry {slot, value, operation}; each gives one result
// beat on out_*. Operations: sample, load edge, read bin count, clear.
// Configuration via cfg_we/cfg_idx/cfg_data only while idle.
// Path: an input beat is captured in S_IDLE and passes S_RD, S_BIN and S_WR;
// the result beat is registered in S_OUT. A clear sweeps the count memory
// after its result beat has left. One item at a time: a new input beat is
// not taken until the count memory read-modify-write (bin, read,
// increment/write) is through and the result beat has left.
// Edge mode: a row of MAX_BINS edge cells plus a top-edge register compares
// in parallel, one per edge; a priority pick of the first hit gives the bin,
// and the cell of bin n-1 flags a sample at or above the top edge.
// Reset: registers to defaults, then a clearing pass in S_CLR zeroes the
// whole count memory; in_tready stays low meanwhile.
// Stall: the result waits in the output register; a new input beat is not
// taken until the result has left.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module range_clipped_histogram_binner_core
  import rchb_pkg::*;
#(
  parameter int MAX_BINS    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [47:0]   in_tdata,   // operation[1:0] value[33:2] slot[44:34]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [111:0]       out_tdata   // bin_index, in_range, below, above,
                                         // count_read, under_total, over_total
);
  localparam int AW = $clog2(MAX_BINS);
  localparam int EW = $clog2(MAX_BINS + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_BIN, S_WR, S_OUT} st_t;
  st_t st_r;

  logic signed [31:0] lo_r, hi_r;
  logic [10:0] bins_r;
  logic [31:0] scale_r;
  logic        edges_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0; hi_r <= 32'sh7FFFFFFF; bins_r <= 11'd16;
      scale_r <= '0; edges_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RANGE_LOW:  lo_r <= cfg_data;
        REG_RANGE_HIGH: hi_r <= cfg_data;
        REG_BINS:       bins_r <= cfg_data[10:0];
        REG_SCALE:      scale_r <= cfg_data;
        REG_USE_EDGES:  edges_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // active bin count n, clamped to 1..MAX_BINS
  logic [EW-1:0] n;
  always_comb begin
    if (bins_r == 11'd0) n = EW'(1);
    else if (32'(bins_r) > 32'(MAX_BINS)) n = EW'(MAX_BINS);
    else n = EW'(bins_r);
  end

  // captured input
  logic [1:0]         op_r;
  logic signed [31:0] x_r;
  logic [10:0]        slot_r;

  // edge cell row
  logic signed [31:0] edge_q [MAX_BINS+1];
  tok_t               cres   [MAX_BINS];
  logic               tok_r;
  logic [EW-1:0]      ld_sel;
  assign ld_sel = EW'(slot_r);
  logic ld_go;
  assign ld_go = (st_r == S_RD) && (op_r == OP_LOAD) && (32'(slot_r) <= 32'(MAX_BINS));

  genvar g;
  generate
    for (g = 0; g < MAX_BINS; g++) begin : g_cell
      rchb_cell u_cell (
        .clk(clk), .rst_n(rst_n),
        .load_en(ld_go && ld_sel == EW'(g)), .load_val(x_r),
        .next_edge(edge_q[g+1]), .is_last(EW'(g + 1) == n),
        .tok_in(tok_r), .x(x_r), .edge_q(edge_q[g]), .res(cres[g])
      );
    end
  endgenerate
  logic signed [31:0] top_edge_r;
  always_ff @(posedge clk) begin
    if (ld_go && ld_sel == EW'(MAX_BINS)) top_edge_r <= x_r;
  end
  assign edge_q[MAX_BINS] = top_edge_r;

  // first hit among cells below n; top-edge flags from the last cell in use
  logic          hit;
  logic          top_eq;
  logic          top_gt;
  logic [AW-1:0] hit_idx;
  always_comb begin
    hit = 1'b0; hit_idx = '0; top_eq = 1'b0; top_gt = 1'b0;
    for (int i = MAX_BINS - 1; i >= 0; i--) begin
      if (cres[i].vld && cres[i].found && EW'(i) < n) begin
        hit = 1'b1; hit_idx = AW'(i);
      end
      if (cres[i].vld && cres[i].top_eq) top_eq = 1'b1;
      if (cres[i].vld && cres[i].top_gt) top_gt = 1'b1;
    end
  end

  // uniform bin
  logic [31:0] d;
  logic [63:0] prod;
  logic [31:0] k;
  assign d    = 32'(x_r - lo_r);
  assign prod = 64'(d) * 64'(scale_r);
  assign k    = prod[63:32];

  // classification, registered from S_RD
  logic below_r, above_r, inr_r;
  logic [AW-1:0] bin_r;
  logic below_nxt, above_nxt, inr_nxt;
  logic [AW-1:0] bin_nxt;
  always_comb begin
    below_nxt = 1'b0; above_nxt = 1'b0; inr_nxt = 1'b0; bin_nxt = '0;
    if (op_r == OP_SAMPLE) begin
      if (x_r < lo_r) below_nxt = 1'b1;
      else if (x_r > hi_r) above_nxt = 1'b1;
      else if (edges_r) begin
        if (x_r < edge_q[0]) below_nxt = 1'b1;
        else if (top_gt) above_nxt = 1'b1;
        else if (hit) begin inr_nxt = 1'b1; bin_nxt = hit_idx; end
        else if (top_eq) begin inr_nxt = 1'b1; bin_nxt = AW'(n - EW'(1)); end
        else above_nxt = 1'b1;
      end else begin
        inr_nxt = 1'b1;
        bin_nxt = (33'(k) >= 33'(n)) ? AW'(n - EW'(1)) : AW'(k);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (st_r == S_RD) begin
      below_r <= below_nxt; above_r <= above_nxt; inr_r <= inr_nxt; bin_r <= bin_nxt;
    end
  end

  // count memory
  logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic [AW-1:0] raddr, clr_r;
  logic          mwe;
  logic [AW-1:0] waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  assign raddr = (op_r == OP_READ) ? AW'(slot_r) : bin_r;
  always_ff @(posedge clk) begin
    if (mwe) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end
  always_comb begin
    mwe = 1'b0; waddr = clr_r; wdata = '0;
    if (st_r == S_CLR) mwe = 1'b1;
    else if (st_r == S_WR && op_r == OP_SAMPLE && inr_r) begin
      mwe = 1'b1; waddr = bin_r;
      wdata = (rdata_r == CMAX) ? CMAX : rdata_r + COUNT_WIDTH'(1);
    end
  end

  logic [COUNT_WIDTH-1:0] und_r, ovr_r;
  function automatic logic [31:0] o32(input logic [COUNT_WIDTH-1:0] c);
    return (64'(c) > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; out_tvalid <= 1'b0; tok_r <= 1'b0;
      und_r <= '0; ovr_r <= '0;
    end else begin
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_BINS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[1:0]; x_r <= in_tdata[33:2]; slot_r <= in_tdata[44:34];
          tok_r <= (in_tdata[1:0] == OP_SAMPLE);
          st_r <= S_RD;
        end
        S_RD:  begin st_r <= S_BIN; tok_r <= 1'b0; end
        S_BIN: st_r <= S_WR;
        S_WR: begin
          if (op_r == OP_SAMPLE) begin
            if (below_r && und_r != CMAX) und_r <= und_r + COUNT_WIDTH'(1);
            if (above_r && ovr_r != CMAX) ovr_r <= ovr_r + COUNT_WIDTH'(1);
          end
          if (op_r == OP_CLEAR) begin und_r <= '0; ovr_r <= '0; end
          st_r <= S_OUT; out_tvalid <= 1'b1;
        end
        S_OUT: if (out_tready) begin
          out_tvalid <= 1'b0;
          if (op_r == OP_CLEAR) begin clr_r <= '0; st_r <= S_CLR; end
          else st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
  assign in_tready = (st_r == S_IDLE);

  logic [31:0] cread_r;
  always_ff @(posedge clk) begin
    if (st_r == S_WR) begin
      cread_r <= (op_r == OP_READ && 32'(slot_r) < 32'(MAX_BINS)) ? o32(rdata_r) : '0;
    end
  end
  assign out_tdata = {3'b0, o32(ovr_r), o32(und_r), cread_r,
                      above_r, below_r, inr_r, 10'(bin_r)};
endmodule
`default_nettype wire

/* hdl/rchb_checker.sv */
// ----------------------------------------------------------------------------
// rchb_checker
// Port-level checks of the histogram binner core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "range_clipped_histogram_binner_core_assert.svh"
module rchb_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata
);
  // one item in flight: no input taken while a result waits
  `RCHB_ASSERT_IMP(a_excl, clk, rst_n, out_tvalid, !in_tready)
  // at most one outcome flag per result
  `RCHB_ASSERT_IMP(a_flags, clk, rst_n, out_tvalid, $countones(out_tdata[12:10]) <= 1)
  // stalled result holds
  `RCHB_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  logic unused;
  assign unused = in_tvalid;
endmodule
bind range_clipped_histogram_binner_core rchb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire

/* tb/range_clipped_histogram_binner_core_tb.sv */
// ----------------------------------------------------------------------------
// range_clipped_histogram_binner_core_tb
// Self-checking bench for the range-clipped histogram binner.
// ----------------------------------------------------------------------------
// A short table of directed beats runs first. Rows whose result is plain
// (just after reset, extremes, out-of-range reads) carry a hand-typed result.
// All other rows, and the random phases after them, are checked against a
// behavioural predictor kept inside the bench. Phases cover uniform bins,
// full-scale and overshooting scale, an inverted range, and edge-table bins
// with sorted and scrambled edges. Each phase picks one of four idling modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module range_clipped_histogram_binner_core_tb;
  import rchb_pkg::*;

  localparam int NBINS   = 1024;
  localparam int LIMIT   = 30000;  // idle cycles before the watchdog trips
  localparam int TAIL    = 12;     // cycles waited in drain after the block is idle
  localparam int PHASE_N = 52;     // random beats per phase
  localparam int N_EDGES = 16;     // top edge index loaded for edge mode

  typedef struct packed {
    logic [31:0] over_total;
    logic [31:0] under_total;
    logic [31:0] count_read;
    logic        above;
    logic        below;
    logic        in_range;
    logic [9:0]  bin_index;
  } bin_res_t;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    logic [10:0] slot;
    bit          typed;
    bin_res_t    res;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_idx = '0;
  logic [31:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;   // operation[1:0] value[33:2] slot[44:34]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;       // bin_index[9:0] in_range[10] below[11]
                                 // above[12] count_read[44:13]
                                 // under_total[76:45] over_total[108:77]

  range_clipped_histogram_binner_core i_dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always #5 clk = ~clk;

  // Bench copy of the configuration and the histogram state
  logic signed [31:0] lo_q = 0;
  logic signed [31:0] hi_q = 32'h7FFF_FFFF;
  logic [10:0]        nbins_q = 11'd16;
  logic [31:0]        scale_q = 0;
  logic               edges_q = 0;
  logic [31:0]        hist_q [NBINS];
  logic signed [31:0] edge_q [NBINS+1];
  logic [31:0]        under_q = 0;
  logic [31:0]        over_q = 0;

  bin_res_t expected_q [$];
  int       errors = 0;
  int       in_gap_pct = 0;   // chance of a sender gap after a beat
  int       out_stall_pct = 0;
  int       idle_cycles = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Works out the result of one beat and updates the bench state.
  function automatic bin_res_t bin_sample(op_t op, logic signed [31:0] x,
                                          logic [10:0] slot);
    bin_res_t r;
    int n;
    logic [63:0] d, k;
    bit hit;
    r = '0;
    n = (nbins_q == 0) ? 1 : (nbins_q > NBINS) ? NBINS : int'(nbins_q);
    case (op)
      OP_SAMPLE: begin
        if (x < lo_q) r.below = 1;
        else if (x > hi_q) r.above = 1;
        else if (edges_q) begin
          if (x < edge_q[0]) r.below = 1;
          else if (x > edge_q[n]) r.above = 1;
          else begin
            hit = 0;
            for (int i = 0; i < n; i++)
              if (!hit && edge_q[i] <= x && x < edge_q[i+1]) begin
                hit = 1;
                r.bin_index = 10'(i);
              end
            if (!hit && x == edge_q[n]) begin
              hit = 1;
              r.bin_index = 10'(n - 1);
            end
            if (hit) r.in_range = 1; else r.above = 1;
          end
        end else begin
          d = 64'(signed'(65'(x) - 65'(lo_q)));
          k = (d * 64'(scale_q)) >> 32;
          if (k >= 64'(n)) k = 64'(n - 1);
          r.bin_index = k[9:0];
          r.in_range = 1;
        end
        if (r.in_range) hist_q[r.bin_index] = sat_inc(hist_q[r.bin_index]);
        if (r.below) under_q = sat_inc(under_q);
        if (r.above) over_q = sat_inc(over_q);
      end
      OP_LOAD: if (slot <= NBINS) edge_q[slot] = x;
      OP_READ: if (slot < NBINS) r.count_read = hist_q[slot];
      default: begin
        foreach (hist_q[i]) hist_q[i] = 0;
        under_q = 0;
        over_q = 0;
      end
    endcase
    r.under_total = under_q;
    r.over_total = over_q;
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1; cfg_idx = idx; cfg_data = d;
    case (idx)
      REG_RANGE_LOW:  lo_q = d;
      REG_RANGE_HIGH: hi_q = d;
      REG_BINS:       nbins_q = d[10:0];
      REG_SCALE:      scale_q = d;
      default:        edges_q = d[0];
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Drives one beat, waits for it to be taken, and queues its result.
  task automatic send_beat(op_t op, logic [31:0] v, logic [10:0] slot,
                           bit typed = 0, bin_res_t typed_res = '0);
    bin_res_t p;
    if (!in_tvalid || $urandom_range(99) < in_gap_pct) begin
      in_tvalid = 0;
      if (in_gap_pct != 0) repeat ($urandom_range(4)) @(negedge clk);
    end
    in_tdata = {3'b0, slot, v, op};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    p = bin_sample(op, v, slot);
    expected_q.push_back(typed ? typed_res : p);
    @(negedge clk);
  endtask

  // Lets the block go idle, clearing sweep included, before a register write.
  task automatic drain;
    in_tvalid = 0;
    while (expected_q.size() != 0) @(negedge clk);
    while (!in_tready) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  task automatic set_uniform(logic signed [31:0] lo, logic signed [31:0] hi,
                             logic [10:0] nb);
    logic [63:0] w, s;
    w = 64'(signed'(65'(hi) - 65'(lo)));
    s = (w == 0) ? 64'hFFFF_FFFF : ((64'(nb) << 32) / w);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_BINS, {21'b0, nb});
    write_reg(REG_SCALE, (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0]);
  endtask

  // Evenly spaced edges from lo upwards, clamped at the signed maximum.
  task automatic load_edges(logic signed [31:0] lo, logic signed [31:0] step,
                            int top);
    longint e;
    for (int i = 0; i <= top; i++) begin
      e = longint'(lo) + longint'(i) * longint'(step);
      if (e > 64'sh7FFF_FFFF) e = 64'sh7FFF_FFFF;
      send_beat(OP_LOAD, e[31:0], i[10:0]);
    end
  endtask

  function automatic logic [31:0] pick_value();
    int n;
    logic [31:0] v;
    n = (nbins_q == 0) ? 1 : (nbins_q > NBINS) ? NBINS : int'(nbins_q);
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(1) ? lo_q : hi_q;
      2: v = edges_q ? edge_q[$urandom_range(n)] + $urandom_range(2) - 1
                     : lo_q + $urandom_range(2) - 1;
      3: v = edges_q ? edge_q[$urandom_range(n)] : hi_q + $urandom_range(2) - 1;
      default: v = lo_q + $urandom_range(32'hFFFF_FFFF) %
                   ((hi_q > lo_q) ? (32'(hi_q - lo_q) | 32'h1) : 32'h1);
    endcase
    return v;
  endfunction

  task automatic random_phase(int mode);
    int sel;
    logic [10:0] s;
    case (mode)
      0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
      1: begin in_gap_pct = 73; out_stall_pct = 0;  end
      2: begin in_gap_pct = 0;  out_stall_pct = 73; end
      default: begin in_gap_pct = 18; out_stall_pct = 18; end
    endcase
    for (int i = 0; i < PHASE_N; i++) begin
      sel = $urandom_range(99);
      s = $urandom;
      if (sel < 70) send_beat(OP_SAMPLE, pick_value(), s);
      else if (sel < 90)
        send_beat(OP_READ, $urandom, $urandom_range(1) ? s : {6'b0, s[4:0]});
      else if (sel < 98)
        // half the loads go to the low slots so scrambled edges matter
        send_beat(OP_LOAD, pick_value(), $urandom_range(1) ? s : {7'b0, s[3:0]});
      else send_beat(OP_CLEAR, $urandom, s);
    end
  endtask

  // Receiver back-pressure changes on the falling edge only
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= out_stall_pct);

  // Result checker and watchdog
  always @(posedge clk) begin
    bin_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[108:0];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: bin %0d/%0d in %b/%b below %b/%b above %b/%b ",
                     want.bin_index, got.bin_index, want.in_range, got.in_range,
                     want.below, got.below, want.above, got.above,
                     "read %h/%h under %h/%h over %h/%h",
                     want.count_read, got.count_read, want.under_total,
                     got.under_total, want.over_total, got.over_total);
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("range_clipped_histogram_binner_core regression: fail");
      $finish;
    end
  end

  function automatic bin_res_t mk(logic [9:0] b, logic inr, logic bl, logic ab,
                                  logic [31:0] cr, logic [31:0] ut);
    bin_res_t r;
    r = '{over_total: 32'd0, under_total: ut, count_read: cr, above: ab,
          below: bl, in_range: inr, bin_index: b};
    return r;
  endfunction

  dir_row_t rows [$];

  initial begin
    foreach (hist_q[i]) hist_q[i] = 0;
    // Reset defaults: range 0..max, sixteen bins, scale zero puts all in bin 0
    rows = '{
      '{OP_SAMPLE, 32'h0000_0000, 11'd0,    1, mk(0, 1, 0, 0, 0, 0)},
      '{OP_SAMPLE, 32'hFFFF_FFFF, 11'd2047, 1, mk(0, 0, 1, 0, 0, 1)},
      '{OP_SAMPLE, 32'h8000_0000, 11'd0,    1, mk(0, 0, 1, 0, 0, 2)},
      '{OP_SAMPLE, 32'h7FFF_FFFF, 11'd0,    1, mk(0, 1, 0, 0, 0, 2)},
      '{OP_READ,   32'hFFFF_FFFF, 11'd0,    1, mk(0, 0, 0, 0, 2, 2)},
      '{OP_READ,   32'h0,         11'd1024, 1, mk(0, 0, 0, 0, 0, 2)},
      '{OP_READ,   32'h0,         11'd2047, 1, mk(0, 0, 0, 0, 0, 2)},
      '{OP_LOAD,   32'h1234_5678, 11'd2047, 1, mk(0, 0, 0, 0, 0, 2)},
      '{OP_CLEAR,  32'hFFFF_FFFF, 11'd2047, 1, mk(0, 0, 0, 0, 0, 0)},
      '{OP_READ,   32'h0,         11'd0,    1, mk(0, 0, 0, 0, 0, 0)},
      '{OP_SAMPLE, 32'h0001_0000, 11'd0,    0, '0},
      '{OP_READ,   32'h0,         11'd1023, 0, '0}
    };
    repeat (6) @(negedge clk);
    rst_n = 1;

    foreach (rows[i]) send_beat(rows[i].op, rows[i].value, rows[i].slot,
                                rows[i].typed, rows[i].res);
    drain();

    // Moderate uniform histogram
    set_uniform(-32'sd1048576, 32'sd1048576, 11'd16);
    random_phase(0);
    drain();

    // Full signed range, all bins; then a scale that overshoots the top bin
    set_uniform(32'sh8000_0000, 32'sh7FFF_FFFF, 11'd1024);
    random_phase(1);
    drain();
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_BINS, 11'd0);
    random_phase(2);
    drain();

    // Inverted range: anything not below low is overflow
    set_uniform(32'sd500000, -32'sd500000, 11'd2047);
    random_phase(3);
    drain();

    // Edge bins: every edge in use written before edge mode is switched on
    write_reg(REG_RANGE_LOW, -32'sd3000000);
    write_reg(REG_RANGE_HIGH, 32'sd3000000);
    load_edges(-32'sd2000000, 32'sd250000, N_EDGES);
    drain();
    write_reg(REG_BINS, 11'd8);
    write_reg(REG_USE_EDGES, 32'd1);
    random_phase(0);
    drain();
    write_reg(REG_BINS, 11'(N_EDGES));
    random_phase(2);
    drain();
    write_reg(REG_RANGE_LOW, 32'sh8000_0000);
    write_reg(REG_RANGE_HIGH, 32'sh7FFF_FFFF);
    write_reg(REG_BINS, 11'd1);
    random_phase(3);
    drain();

    // Back to uniform with a single bin
    write_reg(REG_USE_EDGES, 32'd0);
    set_uniform(32'sh8000_0000, 32'sh7FFF_FFFF, 11'd1);
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    random_phase(1);
    drain();

    if (errors == 0)
      $display("range_clipped_histogram_binner_core regression: pass");
    else
      $display("range_clipped_histogram_binner_core regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/rchb_pkg.sv
hdl/rchb_cell.sv
hdl/range_clipped_histogram_binner_core.sv
hdl/rchb_checker.sv
tb/range_clipped_histogram_binner_core_tb.sv
